// ===== rtl/weighted_light_sampler_core_defines.svh =====
// ----------------------------------------------------------------------------
// weighted light sampler assertion macros
// wraps concurrent assertions so they can be compiled out as a group
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_LIGHT_SAMPLER_CORE_DEFINES_SVH
`define WEIGHTED_LIGHT_SAMPLER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// property holds at every edge outside reset
`define WLS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition in one cycle implies a result in the next
`define WLS_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`else

`define WLS_ASSERT(lbl, clk, rst_n, prop, msg)

`define WLS_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)

`endif

`endif

// ===== rtl/wls_pkg.sv =====
// ----------------------------------------------------------------------------
// wls_pkg
// shared widths, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package wls_pkg;

	// default sizing
	localparam int MAX_LIGHTS_DEF  = 64;
	localparam int WEIGHT_BITS_DEF = 16;
	localparam int WEIGHT_BITS_MAX = 32;

	// transaction field widths
	localparam int OP_W      = 2;
	localparam int WEIGHT_W  = 16;
	localparam int FRAC_W    = 16;
	localparam int IDX_OUT_W = 6;
	localparam int PROB_W    = 17;
	localparam int STAT_W    = 2;

	// divider step counter
	localparam int DCNT_W = $clog2(PROB_W + 1);

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_SAMPLE = 2'd2
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic    capture;
		logic    clear;
		logic    append;
		logic    search_init;
		logic    read_mid;
		logic    step;
		logic    read_lo;
		logic    div_init;
		logic    div_step;
		logic    load_out;
		logic    out_sample;
		status_t out_status;
	} wls_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic full;
		logic empty;
		logic search_go;
		logic div_last;
	} wls_stat_t;

endpackage

// ===== rtl/weighted_light_sampler_core.sv =====
// ----------------------------------------------------------------------------
// weighted_light_sampler_core
// clear, append and unused codes go from the execute state to the finish state, where the result registers
// sample: a read state and a compare state per search step (at most clog2(entries+1) steps, 7 for 64)
// one transaction at a time, next accepted the cycle after the result registers
// the 17-step restoring divider and the memory-read-then-compare search step set the rate
// reset clears the entry count and total at once; table contents stay unwritten
// ----------------------------------------------------------------------------
module weighted_light_sampler_core import wls_pkg::*; #(
	parameter int MAX_LIGHTS  = MAX_LIGHTS_DEF,
	parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  logic [OP_W-1:0]      operation,
	input  logic [WEIGHT_W-1:0]  weight,
	input  logic [FRAC_W-1:0]    random_fraction,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic [IDX_OUT_W-1:0] light_index,
	output logic [PROB_W-1:0]    probability,
	output logic [STAT_W-1:0]    status
);

	wls_cmd_t  cmd;
	wls_stat_t stat;

	// sequencer
	wls_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.operation    (operation),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.stat         (stat),
		.cmd          (cmd)
	);

	// table, search and divide
	wls_datapath #(
		.MAX_LIGHTS  (MAX_LIGHTS),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.weight          (weight),
		.random_fraction (random_fraction),
		.light_index     (light_index),
		.probability     (probability),
		.status          (status)
	);

endmodule

// ===== rtl/wls_ctrl.sv =====
// ----------------------------------------------------------------------------
// wls_ctrl
// sequencer for clear, append and the search plus divide of a sample
// ----------------------------------------------------------------------------
`include "weighted_light_sampler_core_defines.svh"

module wls_ctrl import wls_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_stall,
	input  logic [OP_W-1:0] operation,
	output logic            result_valid,
	input  logic            result_stall,
	input  wls_stat_t       stat,
	output wls_cmd_t        cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SRD,
		S_SCMP,
		S_WLD,
		S_DIV,
		S_FIN
	} state_t;

	state_t  state_q;
	op_t     op_q;
	status_t res_status_q;
	logic    res_sample_q;
	logic    out_valid_q;
	logic [9:0] cmd_vec;

	assign item_stall   = (state_q != S_IDLE);
	assign result_valid = out_valid_q;

	// command decode
	always_comb begin
		cmd            = '0;
		cmd.out_status = res_status_q;
		cmd.out_sample = res_sample_q;
		unique case (state_q)
			S_IDLE: cmd.capture = item_valid;
			S_EXEC: begin
				case (op_q)
					OP_CLEAR:  cmd.clear = 1'b1;
					OP_APPEND: cmd.append = !stat.full;
					OP_SAMPLE: cmd.search_init = !stat.empty;
					default:   ;
				endcase
			end
			S_SRD: begin
				cmd.read_mid = stat.search_go;
				cmd.read_lo  = !stat.search_go;
			end
			S_SCMP: cmd.step = 1'b1;
			S_WLD:  cmd.div_init = 1'b1;
			S_DIV:  cmd.div_step = 1'b1;
			S_FIN:  cmd.load_out = !out_valid_q || !result_stall;
			default: ;
		endcase
	end

	// state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_valid_q  <= 1'b0;
			op_q         <= OP_CLEAR;
			res_status_q <= ST_OK;
			res_sample_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						op_q    <= op_t'(operation);
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					res_status_q <= ST_OK;
					res_sample_q <= 1'b0;
					state_q      <= S_FIN;
					case (op_q)
						OP_APPEND: begin
							if (stat.full) begin
								res_status_q <= ST_FULL;
							end
						end
						OP_SAMPLE: begin
							if (stat.empty) begin
								res_status_q <= ST_EMPTY;
							end else begin
								res_sample_q <= 1'b1;
								state_q      <= S_SRD;
							end
						end
						default: ;
					endcase
				end
				S_SRD: begin
					state_q <= stat.search_go ? S_SCMP : S_WLD;
				end
				S_SCMP: state_q <= S_SRD;
				S_WLD:  state_q <= S_DIV;
				S_DIV: begin
					if (stat.div_last) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (cmd.load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign cmd_vec = {cmd.capture, cmd.clear, cmd.append, cmd.search_init, cmd.read_mid,
		cmd.step, cmd.read_lo, cmd.div_init, cmd.div_step, cmd.load_out};

	// checks
	`WLS_ASSERT(a_one_action, clk, arst_n, $onehot0(cmd_vec), "more than one datapath action")
	`WLS_ASSERT_NEXT(a_fin_delivers, clk, arst_n, (state_q == S_FIN) && !(out_valid_q && result_stall), out_valid_q && (state_q == S_IDLE), "finished transaction not delivered")

endmodule

// ===== rtl/wls_datapath.sv =====
// ----------------------------------------------------------------------------
// wls_datapath
// cumulative weight memory, search registers, target multiply and divider
// ----------------------------------------------------------------------------
`include "weighted_light_sampler_core_defines.svh"

module wls_datapath import wls_pkg::*; #(
	parameter int MAX_LIGHTS  = MAX_LIGHTS_DEF,
	parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  wls_cmd_t             cmd,
	output wls_stat_t            stat,
	input  logic [WEIGHT_W-1:0]  weight,
	input  logic [FRAC_W-1:0]    random_fraction,
	output logic [IDX_OUT_W-1:0] light_index,
	output logic [PROB_W-1:0]    probability,
	output logic [STAT_W-1:0]    status
);

	localparam int IDX_W  = $clog2(MAX_LIGHTS);
	localparam int CNT_W  = $clog2(MAX_LIGHTS + 1);
	localparam int SUM_W  = WEIGHT_BITS + IDX_W;
	localparam int TGT_W  = SUM_W + FRAC_W;
	localparam int WORD_W = WEIGHT_BITS + SUM_W;
	localparam int REM_W  = SUM_W + 1;

	// table memory: entry weight over cumulative sum
	logic [WORD_W-1:0] ram_q [MAX_LIGHTS];

	logic [CNT_W-1:0]       cnt_q;
	logic [SUM_W-1:0]       total_q;
	logic [WEIGHT_BITS-1:0] w_q;
	logic [FRAC_W-1:0]      frac_q;
	logic [TGT_W-1:0]       target_q;
	logic [CNT_W-1:0]       lo_q;
	logic [CNT_W-1:0]       hi_q;
	logic [IDX_W-1:0]       mid_q;
	logic [WORD_W-1:0]      rd_q;
	logic [IDX_W-1:0]       idx_q;
	logic [REM_W-1:0]       rem_q;
	logic [PROB_W-1:0]      quo_q;
	logic [DCNT_W-1:0]      dcnt_q;
	logic [IDX_OUT_W-1:0]   light_index_q;
	logic [PROB_W-1:0]      probability_q;
	logic [STAT_W-1:0]      status_q;

	logic [WEIGHT_BITS_MAX-1:0] weight_wide;
	logic [WEIGHT_BITS-1:0]     w_in;
	logic [SUM_W-1:0]           new_total;
	logic [CNT_W:0]             mid_sum;
	logic [IDX_W-1:0]           mid_idx;
	logic [CNT_W-1:0]           lo_clamp;
	logic [IDX_W-1:0]           lo_idx;
	logic [IDX_W-1:0]           rd_addr;
	logic [SUM_W-1:0]           rd_cum;
	logic [WEIGHT_BITS-1:0]     rd_w;
	logic                       below;
	logic [TGT_W-1:0]           product;
	logic [REM_W-1:0]           total_ext;
	logic                       ge;
	logic [REM_W-1:0]           rem_sub;

	// input weight trimmed to the configured width
	assign weight_wide = WEIGHT_BITS_MAX'(weight);
	assign w_in        = weight_wide[WEIGHT_BITS-1:0];
	assign new_total   = total_q + SUM_W'(w_q);

	// search address arithmetic
	assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid_idx  = mid_sum[IDX_W:1];
	assign lo_clamp = (lo_q >= cnt_q) ? (cnt_q - CNT_W'(1)) : lo_q;
	assign lo_idx   = lo_clamp[IDX_W-1:0];
	assign rd_addr  = cmd.read_mid ? mid_idx : lo_idx;
	assign rd_cum   = rd_q[SUM_W-1:0];
	assign rd_w     = rd_q[WORD_W-1:SUM_W];
	assign below    = {rd_cum, {FRAC_W{1'b0}}} < target_q;

	// target scale and divider step
	assign product   = TGT_W'(frac_q) * TGT_W'(total_q);
	assign total_ext = {1'b0, total_q};
	assign ge        = rem_q >= total_ext;
	assign rem_sub   = ge ? (rem_q - total_ext) : rem_q;

	// status to controller
	assign stat.full      = (cnt_q == CNT_W'(MAX_LIGHTS));
	assign stat.empty     = (cnt_q == '0) || (total_q == '0);
	assign stat.search_go = (lo_q < hi_q);
	assign stat.div_last  = (dcnt_q == DCNT_W'(1));

	// memory write and registered read
	always_ff @(posedge clk) begin
		if (cmd.append) begin
			ram_q[cnt_q[IDX_W-1:0]] <= {w_q, new_total};
		end
		if (cmd.read_mid || cmd.read_lo) begin
			rd_q <= ram_q[rd_addr];
		end
	end

	// table occupancy, total and divider step count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			total_q <= '0;
			dcnt_q  <= '0;
		end else begin
			if (cmd.clear) begin
				cnt_q   <= '0;
				total_q <= '0;
			end else if (cmd.append) begin
				cnt_q   <= cnt_q + CNT_W'(1);
				total_q <= new_total;
			end
			if (cmd.div_init) begin
				dcnt_q <= DCNT_W'(PROB_W);
			end else if (cmd.div_step) begin
				dcnt_q <= dcnt_q - DCNT_W'(1);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			w_q    <= w_in;
			frac_q <= random_fraction;
		end
		if (cmd.search_init) begin
			target_q <= product;
			lo_q     <= '0;
			hi_q     <= cnt_q;
		end
		if (cmd.read_mid) begin
			mid_q <= mid_idx;
		end
		if (cmd.step) begin
			if (below) begin
				lo_q <= CNT_W'(mid_q) + CNT_W'(1);
			end else begin
				hi_q <= CNT_W'(mid_q);
			end
		end
		if (cmd.read_lo) begin
			idx_q <= lo_idx;
		end
		if (cmd.div_init) begin
			rem_q <= REM_W'(rd_w);
			quo_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= {rem_sub[SUM_W-1:0], 1'b0};
			quo_q <= {quo_q[PROB_W-2:0], ge};
		end
		if (cmd.load_out) begin
			light_index_q <= cmd.out_sample ? IDX_OUT_W'(idx_q) : '0;
			probability_q <= cmd.out_sample ? quo_q : '0;
			status_q      <= cmd.out_status;
		end
	end

	assign light_index = light_index_q;
	assign probability = probability_q;
	assign status      = status_q;

	// checks
	`WLS_ASSERT(a_cnt_range, clk, arst_n, cnt_q <= CNT_W'(MAX_LIGHTS), "entry count past table size")
	`WLS_ASSERT(a_lo_valid, clk, arst_n, cmd.read_lo |-> (lo_clamp < cnt_q), "clamped index outside table")
	`WLS_ASSERT(a_prob_range, clk, arst_n, (cmd.load_out && cmd.out_sample) |-> (quo_q <= PROB_W'(65536)), "probability above one")

endmodule

// ===== test/weighted_light_sampler_core_tb.sv =====
// ----------------------------------------------------------------------------
// weighted_light_sampler_core_tb
// drives clear, append and sample transactions into the light sampler and
// checks every result against a cycle-free model of the cumulative weight
// table, with random gaps on the item side and random stalls on the result side
// ----------------------------------------------------------------------------
module weighted_light_sampler_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import wls_pkg::*;

	// opcode the block must ignore
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int LIGHT_SLOTS = MAX_LIGHTS_DEF;
	localparam int ITEM_TARGET = 1900;
	localparam int SETTLE_CYCLES = 50;

	typedef struct packed {
		logic [IDX_OUT_W-1:0] light_index;
		logic [PROB_W-1:0]    probability;
		status_t              status;
	} light_pick_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 item_valid = 1'b0;
	logic                 item_stall;
	logic [OP_W-1:0]      operation = '0;
	logic [WEIGHT_W-1:0]  weight = '0;
	logic [FRAC_W-1:0]    random_fraction = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	logic [IDX_OUT_W-1:0] light_index;
	logic [PROB_W-1:0]    probability;
	logic [STAT_W-1:0]    status;

	// model of the light table
	logic [21:0]         cum_tbl [LIGHT_SLOTS];
	logic [WEIGHT_W-1:0] weight_tbl [LIGHT_SLOTS];
	logic [6:0]          light_count = '0;
	logic [21:0]         weight_total = '0;

	light_pick_t pending_picks[$];
	int          mismatches = 0;
	int          items_sent = 0;
	bit          tx_idling = 1'b0;
	bit          rx_idling = 1'b0;
	int          stall_left = 0;

	weighted_light_sampler_core dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (item_valid),
		.item_stall      (item_stall),
		.operation       (operation),
		.weight          (weight),
		.random_fraction (random_fraction),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.light_index     (light_index),
		.probability     (probability),
		.status          (status)
	);

	always #5 clk = ~clk;

	// gap length: often none, mostly short, a few long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [WEIGHT_W-1:0] rand_weight();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return WEIGHT_W'($urandom_range(0, 15));
			default: return WEIGHT_W'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic [FRAC_W-1:0] rand_fraction();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return FRAC_W'($urandom_range(0, 65535));
		endcase
	endfunction

	// apply one transaction to the table model and return the expected pick
	function automatic light_pick_t update_light_table(logic [OP_W-1:0] op,
		logic [WEIGHT_W-1:0] w, logic [FRAC_W-1:0] frac);
		light_pick_t pick;
		logic [37:0] target;
		int          sel;
		pick = '0;
		case (op)
			OP_CLEAR: begin
				light_count = '0;
				weight_total = '0;
			end
			OP_APPEND: begin
				if (light_count >= LIGHT_SLOTS) begin
					pick.status = ST_FULL;
				end else begin
					weight_total = weight_total + 22'(w);
					weight_tbl[light_count] = w;
					cum_tbl[light_count] = weight_total;
					light_count = light_count + 7'd1;
				end
			end
			OP_SAMPLE: begin
				if (light_count == 0 || weight_total == 0) begin
					pick.status = ST_EMPTY;
				end else begin
					// first entry whose scaled running sum reaches the target,
					// the last entry if none does
					target = 38'(frac) * 38'(weight_total);
					sel = int'(light_count) - 1;
					for (int i = int'(light_count) - 1; i >= 0; i--)
						if ({cum_tbl[i], 16'h0} >= target) sel = i;
					pick.light_index = sel[IDX_OUT_W-1:0];
					pick.probability = PROB_W'((48'(weight_tbl[sel]) << 16) /
						48'(weight_total));
				end
			end
			default: ;
		endcase
		return pick;
	endfunction

	// present one transaction, wait for acceptance, then maybe idle
	task automatic send_item(input logic [OP_W-1:0] op, input logic [WEIGHT_W-1:0] w,
		input logic [FRAC_W-1:0] frac);
		int gap;
		item_valid <= 1'b1;
		operation <= op;
		weight <= w;
		random_fraction <= frac;
		do @(posedge clk); while (item_stall);
		pending_picks.push_back(update_light_table(op, w, frac));
		items_sent++;
		gap = tx_idling ? idle_len() : 0;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// hold the sender until every outstanding result is back
	task automatic drain_results();
		item_valid <= 1'b0;
		while (pending_picks.size() != 0) @(posedge clk);
	endtask

	// result side backpressure
	always @(posedge clk) begin
		if (stall_left > 0) begin
			result_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (rx_idling && $urandom_range(0, 3) == 0) begin
			result_stall <= 1'b1;
			stall_left <= idle_len();
		end else begin
			result_stall <= 1'b0;
		end
	end

	// compare each accepted result with the oldest expected pick
	always @(posedge clk) begin : check_result
		light_pick_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_picks.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result: index %0d probability %0d status %0d",
					$time, light_index, probability, status);
			end else begin
				want = pending_picks.pop_front();
				if (light_index !== want.light_index) begin
					mismatches++;
					$display("%0t: light_index expected %0d actual %0d",
						$time, want.light_index, light_index);
				end
				if (probability !== want.probability) begin
					mismatches++;
					$display("%0t: probability expected %0d actual %0d",
						$time, want.probability, probability);
				end
				if (status !== want.status) begin
					mismatches++;
					$display("%0t: status expected %0d actual %0d",
						$time, want.status, status);
				end
			end
		end
	end

	// empty table, zero total and the unused opcode, no idling
	task automatic test_empty_and_unused();
		tx_idling = 1'b0;
		rx_idling = 1'b0;
		send_item(OP_SAMPLE, '0, '1);
		send_item(OP_UNUSED, '1, '1);
		send_item(OP_APPEND, '0, '0);
		send_item(OP_SAMPLE, '0, '0);
		send_item(OP_CLEAR, '1, '1);
	endtask

	// leading zero weight, full probability, truncation and fraction extremes
	task automatic test_table_edges();
		tx_idling = 1'b1;
		rx_idling = 1'b1;
		send_item(OP_APPEND, '0, '0);
		send_item(OP_APPEND, '1, '0);
		send_item(OP_SAMPLE, '0, '0);
		send_item(OP_SAMPLE, '0, '1);
		send_item(OP_SAMPLE, '0, 16'h8000);
		send_item(OP_CLEAR, '0, '0);
		send_item(OP_APPEND, 16'd1, '0);
		send_item(OP_SAMPLE, '0, 16'h1234);
		send_item(OP_APPEND, 16'hAAAA, '0);
		send_item(OP_APPEND, 16'h5555, '0);
		send_item(OP_APPEND, 16'd3, '0);
		send_item(OP_SAMPLE, '0, '0);
		send_item(OP_SAMPLE, '0, 16'h0001);
		send_item(OP_SAMPLE, '0, 16'h7FFF);
		send_item(OP_SAMPLE, '0, 16'hFFFE);
		send_item(OP_SAMPLE, '0, '1);
	endtask

	// append past capacity, then draw from the full table
	task automatic test_fill_to_capacity();
		send_item(OP_CLEAR, rand_weight(), rand_fraction());
		while (light_count < LIGHT_SLOTS) send_item(OP_APPEND, rand_weight(), rand_fraction());
		repeat (2) send_item(OP_APPEND, rand_weight(), rand_fraction());
		repeat (4) send_item(OP_SAMPLE, rand_weight(), rand_fraction());
	endtask

	// a pause with nothing outstanding, then more draws on the same table
	task automatic test_drain_pause();
		repeat (3) send_item(OP_SAMPLE, rand_weight(), rand_fraction());
		drain_results();
		repeat (3) send_item(OP_SAMPLE, rand_weight(), rand_fraction());
	endtask

	// random tables built by append runs and probed by draws, plus some noise
	task automatic test_random_sequences();
		int r;
		int n;
		while (items_sent < ITEM_TARGET) begin
			tx_idling = ($urandom_range(0, 4) != 0);
			rx_idling = ($urandom_range(0, 4) != 0);
			r = $urandom_range(0, 19);
			if (r < 2) begin
				repeat ($urandom_range(1, 4))
					send_item(OP_W'($urandom_range(0, 3)), rand_weight(), rand_fraction());
			end else if (r == 2) begin
				test_fill_to_capacity();
			end else begin
				// occasionally keep the old table and grow it further
				if (r != 3) send_item(OP_CLEAR, rand_weight(), rand_fraction());
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
				repeat (n) begin
					send_item(OP_APPEND, rand_weight(), rand_fraction());
					if ($urandom_range(0, 7) == 0)
						send_item(OP_SAMPLE, rand_weight(), rand_fraction());
				end
				repeat ($urandom_range(1, 10))
					send_item(OP_SAMPLE, rand_weight(), rand_fraction());
			end
		end
	endtask

	// test sequence
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_and_unused();
		test_table_edges();
		test_fill_to_capacity();
		test_drain_pause();
		test_random_sequences();
		item_valid <= 1'b0;
		while (pending_picks.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// watchdog
	initial begin
		#10ms;
		$display("Mismatches found");
		$finish;
	end

endmodule

// ===== weighted_light_sampler_core.f =====
+incdir+rtl
rtl/wls_pkg.sv
rtl/wls_ctrl.sv
rtl/wls_datapath.sv
rtl/weighted_light_sampler_core.sv
test/weighted_light_sampler_core_tb.sv
